// ===== hdl/fccp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Flux container chunk parser package
// Shared types and constants for the chunk parser.
// ----------------------------------------------------------------------------
package fccp_pkg;

   // Parser phase within the byte stream.
   typedef enum logic [1:0] {
      PHASE_FILE_HDR  = 2'd0,
      PHASE_CHUNK_HDR = 2'd1,
      PHASE_PAYLOAD   = 2'd2
   } phase_type;

   // Chunk ids as little-endian 32-bit words.
   localparam logic [31:0] ID_INFO = 32'h4F46_4E49;
   localparam logic [31:0] ID_STRM = 32'h4D52_5453;

   // Signature characters.
   localparam logic [7:0] SIG_CHAR_0 = 8'h41;  // 'A'
   localparam logic [7:0] SIG_CHAR_1 = 8'h32;  // '2'
   localparam logic [7:0] SIG_CHAR_2 = 8'h52;  // 'R'
   localparam logic [7:0] SIG_VER_2  = 8'h32;  // '2'
   localparam logic [7:0] SIG_VER_3  = 8'h33;  // '3'

   // Header geometry.
   localparam logic [2:0] HDR_LAST_INDEX  = 3'd7;
   localparam logic [2:0] SIG_VER_INDEX   = 3'd3;
   localparam logic [31:0] INFO_MIN_LEN   = 32'd4;

   // Version codes reported in the result.
   localparam logic [1:0] VERSION_NONE = 2'd0;
   localparam logic [1:0] VERSION_2    = 2'd2;
   localparam logic [1:0] VERSION_3    = 2'd3;

endpackage
`default_nettype wire

// ===== hdl/flux_container_chunk_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Flux container chunk parser
// Walks a container byte stream, checks the signature, counts stream chunks
// and their flux bytes, and captures the info chunk fields.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle; the parser state updates once per byte.
// The result is registered: a processed last byte loads the result register and its valid.
// A byte waits in the input register only while a finished result is still
// held in the result register and the byte is itself a last byte.
// Reset: synchronous, active high; clears all parser state and both valids.
// After every last byte the parser state returns to its reset values.
module flux_container_chunk_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_file_valid,
   output logic [1:0]       rsp_format_version,
   output logic [7:0]       rsp_disk_kind,
   output logic             rsp_write_protect,
   output logic             rsp_sync_flag,
   output logic [15:0]      rsp_stream_chunks,
   output logic [31:0]      rsp_flux_bytes
);

   // Input register.
   logic        in_valid_ff;
   logic [7:0]  in_data_ff;
   logic        in_last_ff;

   // Parser state.
   fccp_pkg::phase_type phase_ff, phase_in;
   logic [2:0]  hdr_idx_ff, hdr_idx_in;
   logic        sig_ok_ff, sig_ok_in;
   logic [1:0]  version_ff, version_in;
   logic [31:0] chunk_id_ff, chunk_id_in;
   logic [31:0] chunk_len_ff, chunk_len_in;
   logic [31:0] bytes_left_ff, bytes_left_in;
   logic [23:0] pending_ff, pending_in;
   logic [23:0] committed_ff, committed_in;
   logic [15:0] streams_ff, streams_in;
   logic [31:0] flux_ff, flux_in;

   // Result register.
   logic        rsp_valid_ff;
   logic        res_file_valid_ff;
   logic [1:0]  res_version_ff;
   logic [7:0]  res_disk_kind_ff;
   logic        res_wp_ff;
   logic        res_sync_ff;
   logic [15:0] res_streams_ff;
   logic [31:0] res_flux_ff;

   logic        proc_fire;
   logic        info_tracked;
   logic [31:0] payload_off;
   logic [32:0] flux_sum;
   logic        file_ok;

   // A byte is processed unless it would overwrite a result still waiting.
   assign proc_fire = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || proc_fire;

   assign info_tracked = (chunk_id_ff == fccp_pkg::ID_INFO) &&
                         (chunk_len_ff >= fccp_pkg::INFO_MIN_LEN);
   assign payload_off  = chunk_len_ff - bytes_left_ff;

   // Next phase of the parser.
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         fccp_pkg::PHASE_FILE_HDR: begin
            if (hdr_idx_ff == fccp_pkg::HDR_LAST_INDEX) begin
               phase_in = fccp_pkg::PHASE_CHUNK_HDR;
            end
         end
         fccp_pkg::PHASE_PAYLOAD: begin
            if (bytes_left_in == 32'd0) begin
               phase_in = fccp_pkg::PHASE_CHUNK_HDR;
            end
         end
         default: begin
            if (hdr_idx_ff == fccp_pkg::HDR_LAST_INDEX) begin
               phase_in = (chunk_len_in != 32'd0) ? fccp_pkg::PHASE_PAYLOAD
                                                  : fccp_pkg::PHASE_CHUNK_HDR;
            end
         end
      endcase
   end

   // Datapath update for one byte.
   always_comb begin
      hdr_idx_in    = hdr_idx_ff;
      sig_ok_in     = sig_ok_ff;
      version_in    = version_ff;
      chunk_id_in   = chunk_id_ff;
      chunk_len_in  = chunk_len_ff;
      bytes_left_in = bytes_left_ff;
      pending_in    = pending_ff;
      committed_in  = committed_ff;
      streams_in    = streams_ff;
      flux_in       = flux_ff;
      flux_sum      = 33'd0;
      case (phase_ff)
         fccp_pkg::PHASE_FILE_HDR: begin
            case (hdr_idx_ff)
               3'd0: begin
                  if (in_data_ff != fccp_pkg::SIG_CHAR_0) sig_ok_in = 1'b0;
               end
               3'd1: begin
                  if (in_data_ff != fccp_pkg::SIG_CHAR_1) sig_ok_in = 1'b0;
               end
               3'd2: begin
                  if (in_data_ff != fccp_pkg::SIG_CHAR_2) sig_ok_in = 1'b0;
               end
               fccp_pkg::SIG_VER_INDEX: begin
                  if (in_data_ff != fccp_pkg::SIG_VER_2 &&
                      in_data_ff != fccp_pkg::SIG_VER_3) begin
                     sig_ok_in = 1'b0;
                  end
                  version_in = (in_data_ff == fccp_pkg::SIG_VER_3) ? fccp_pkg::VERSION_3
                                                                  : fccp_pkg::VERSION_2;
               end
               default: begin
               end
            endcase
            hdr_idx_in = hdr_idx_ff + 3'd1;
         end
         fccp_pkg::PHASE_PAYLOAD: begin
            // Capture info payload bytes one to three.
            if (info_tracked && payload_off >= 32'd1 && payload_off <= 32'd3) begin
               pending_in[8*(payload_off[1:0] - 2'd1) +: 8] = in_data_ff;
            end
            if (bytes_left_ff != 32'd0) bytes_left_in = bytes_left_ff - 32'd1;
            if (bytes_left_in == 32'd0) begin
               if (info_tracked) committed_in = pending_in;
               hdr_idx_in = 3'd0;
            end
         end
         default: begin
            // Chunk header: id in bytes 0 to 3, length in bytes 4 to 7.
            if (!hdr_idx_ff[2]) begin
               chunk_id_in[8*hdr_idx_ff[1:0] +: 8] = in_data_ff;
            end else begin
               chunk_len_in[8*hdr_idx_ff[1:0] +: 8] = in_data_ff;
            end
            hdr_idx_in = hdr_idx_ff + 3'd1;
            if (hdr_idx_ff == fccp_pkg::HDR_LAST_INDEX) begin
               if (chunk_id_in == fccp_pkg::ID_STRM) begin
                  if (streams_ff != 16'hFFFF) streams_in = streams_ff + 16'd1;
                  flux_sum = {1'b0, flux_ff} + {1'b0, chunk_len_in};
                  flux_in  = flux_sum[32] ? 32'hFFFF_FFFF : flux_sum[31:0];
               end
               pending_in    = 24'd0;
               bytes_left_in = chunk_len_in;
            end
         end
      endcase
   end

   assign file_ok = (phase_in != fccp_pkg::PHASE_FILE_HDR) && sig_ok_in;

   // Input register: loads on every input transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_data_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   // Parser state: updates per processed byte, clears after the last byte.
   always_ff @(posedge clock) begin
      if (reset || (proc_fire && in_last_ff)) begin
         phase_ff      <= fccp_pkg::PHASE_FILE_HDR;
         hdr_idx_ff    <= 3'd0;
         sig_ok_ff     <= 1'b1;
         version_ff    <= fccp_pkg::VERSION_NONE;
         chunk_id_ff   <= 32'd0;
         chunk_len_ff  <= 32'd0;
         bytes_left_ff <= 32'd0;
         pending_ff    <= 24'd0;
         committed_ff  <= 24'd0;
         streams_ff    <= 16'd0;
         flux_ff       <= 32'd0;
      end else if (proc_fire) begin
         phase_ff      <= phase_in;
         hdr_idx_ff    <= hdr_idx_in;
         sig_ok_ff     <= sig_ok_in;
         version_ff    <= version_in;
         chunk_id_ff   <= chunk_id_in;
         chunk_len_ff  <= chunk_len_in;
         bytes_left_ff <= bytes_left_in;
         pending_ff    <= pending_in;
         committed_ff  <= committed_in;
         streams_ff    <= streams_in;
         flux_ff       <= flux_in;
      end
   end

   // Result register: loads when the last byte is processed.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (proc_fire && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (proc_fire && in_last_ff) begin
         res_file_valid_ff <= file_ok;
         res_version_ff    <= file_ok ? version_in : fccp_pkg::VERSION_NONE;
         res_disk_kind_ff  <= file_ok ? committed_in[7:0] : 8'd0;
         res_wp_ff         <= file_ok && (committed_in[15:8] != 8'd0);
         res_sync_ff       <= file_ok && (committed_in[23:16] != 8'd0);
         res_streams_ff    <= file_ok ? streams_in : 16'd0;
         res_flux_ff       <= file_ok ? flux_in : 32'd0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_file_valid     = res_file_valid_ff;
   assign rsp_format_version = res_version_ff;
   assign rsp_disk_kind      = res_disk_kind_ff;
   assign rsp_write_protect  = res_wp_ff;
   assign rsp_sync_flag      = res_sync_ff;
   assign rsp_stream_chunks  = res_streams_ff;
   assign rsp_flux_bytes     = res_flux_ff;

   // An invalid file reports all fields as zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !res_file_valid_ff |->
         res_version_ff == fccp_pkg::VERSION_NONE && res_disk_kind_ff == 8'd0 &&
         !res_wp_ff && !res_sync_ff && res_streams_ff == 16'd0 && res_flux_ff == 32'd0)
      else $error("invalid file reported nonzero fields");

   // A valid file always carries version two or three.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && res_file_valid_ff |->
         res_version_ff == fccp_pkg::VERSION_2 || res_version_ff == fccp_pkg::VERSION_3)
      else $error("valid file without a version");

   // The parser starts a fresh file after each last byte.
   assert property (@(posedge clock) disable iff (reset)
      proc_fire && in_last_ff |=>
         phase_ff == fccp_pkg::PHASE_FILE_HDR && hdr_idx_ff == 3'd0 && rsp_valid_ff)
      else $error("parser state not cleared after last byte");

   // Payload phase always has bytes outstanding.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == fccp_pkg::PHASE_PAYLOAD |-> bytes_left_ff != 32'd0)
      else $error("payload phase with no bytes left");

endmodule
`default_nettype wire

// ===== dv/flux_container_chunk_parser_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Flux container chunk parser testbench
// Feeds container files one byte per transfer and keeps a byte-accurate
// model of the parser. The model predicts one file summary for every last
// byte, and each summary transfer is checked field by field against it.
// Directed files come first. Random files follow, mostly well formed with
// random content and some broken or noise files, under several idle mixes.
// A long result stall and a flux total saturation run close the test.
// ----------------------------------------------------------------------------
module tb;

   localparam int CYCLE_LIMIT = 100_000;

   // One file summary as it appears on the result channel.
   typedef struct packed {
      logic        file_valid;
      logic [1:0]  format_version;
      logic [7:0]  disk_kind;
      logic        write_protect;
      logic        sync_flag;
      logic [15:0] stream_chunks;
      logic [31:0] flux_bytes;
   } file_summary_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_file_valid;
   logic [1:0]  rsp_format_version;
   logic [7:0]  rsp_disk_kind;
   logic        rsp_write_protect;
   logic        rsp_sync_flag;
   logic [15:0] rsp_stream_chunks;
   logic [31:0] rsp_flux_bytes;

   // Parser model state.
   fccp_pkg::phase_type prs_phase;
   logic [2:0]  prs_index;
   logic        prs_sig_good;
   logic [1:0]  prs_version;
   logic [31:0] prs_id;
   logic [31:0] prs_len;
   logic [31:0] prs_remaining;
   logic [1:0]  prs_payload_count;
   logic [23:0] prs_info_pending;
   logic [23:0] prs_info_committed;
   logic [15:0] prs_strm_count;
   logic [31:0] prs_flux_sum;

   file_summary_type expected_summaries[$];
   file_summary_type head_summary;
   logic [7:0]       file_image[$];

   int fail_count = 0;
   int cycle_count = 0;
   int bytes_sent = 0;
   int files_sent = 0;
   int send_gap_pct = 0;
   int recv_stall_pct = 0;
   int hold_request = 0;
   int hold_left = 0;

   flux_container_chunk_parser DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_file_valid     (rsp_file_valid),
      .rsp_format_version (rsp_format_version),
      .rsp_disk_kind      (rsp_disk_kind),
      .rsp_write_protect  (rsp_write_protect),
      .rsp_sync_flag      (rsp_sync_flag),
      .rsp_stream_chunks  (rsp_stream_chunks),
      .rsp_flux_bytes     (rsp_flux_bytes)
   );

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   // Return the parser model to its state after reset.
   task automatic clear_parser();
      prs_phase          = fccp_pkg::PHASE_FILE_HDR;
      prs_index          = '0;
      prs_sig_good       = 1'b1;
      prs_version        = fccp_pkg::VERSION_NONE;
      prs_id             = '0;
      prs_len            = '0;
      prs_remaining      = '0;
      prs_payload_count  = '0;
      prs_info_pending   = '0;
      prs_info_committed = '0;
      prs_strm_count     = '0;
      prs_flux_sum       = '0;
   endtask

   // Advance the parser model by one byte; a last byte queues a summary.
   task automatic parse_byte(input logic [7:0] b, input logic last);
      int               sh;
      logic [31:0]      offset;
      logic             info_live;
      logic [32:0]      flux_next;
      file_summary_type summary;
      case (prs_phase)
         fccp_pkg::PHASE_FILE_HDR: begin
            case (prs_index)
               3'd0: if (b != fccp_pkg::SIG_CHAR_0) prs_sig_good = 1'b0;
               3'd1: if (b != fccp_pkg::SIG_CHAR_1) prs_sig_good = 1'b0;
               3'd2: if (b != fccp_pkg::SIG_CHAR_2) prs_sig_good = 1'b0;
               fccp_pkg::SIG_VER_INDEX: begin
                  if (b != fccp_pkg::SIG_VER_2 && b != fccp_pkg::SIG_VER_3) begin
                     prs_sig_good = 1'b0;
                  end
                  prs_version = (b == fccp_pkg::SIG_VER_3) ? fccp_pkg::VERSION_3
                                                          : fccp_pkg::VERSION_2;
               end
               default: ;
            endcase
            if (prs_index == fccp_pkg::HDR_LAST_INDEX) begin
               prs_phase = fccp_pkg::PHASE_CHUNK_HDR;
               prs_index = '0;
            end else begin
               prs_index = prs_index + 3'd1;
            end
         end
         fccp_pkg::PHASE_PAYLOAD: begin
            offset = prs_len - prs_remaining;
            info_live = (prs_id == fccp_pkg::ID_INFO) && (prs_len >= fccp_pkg::INFO_MIN_LEN);
            if (info_live && offset >= 32'd1 && offset <= 32'd3) begin
               sh = 8 * (int'(offset) - 1);
               prs_info_pending[sh +: 8] = b;
            end
            if (prs_payload_count != 2'd3) prs_payload_count = prs_payload_count + 2'd1;
            if (prs_remaining != 0) prs_remaining = prs_remaining - 32'd1;
            if (prs_remaining == 0) begin
               if (info_live) prs_info_committed = prs_info_pending;
               prs_phase = fccp_pkg::PHASE_CHUNK_HDR;
               prs_index = '0;
            end
         end
         default: begin
            // Chunk header: id then length, both little endian.
            if (prs_index < 3'd4) begin
               sh = 8 * int'(prs_index);
               prs_id[sh +: 8] = b;
            end else begin
               sh = 8 * (int'(prs_index) - 4);
               prs_len[sh +: 8] = b;
            end
            if (prs_index != fccp_pkg::HDR_LAST_INDEX) begin
               prs_index = prs_index + 3'd1;
            end else begin
               prs_index = '0;
               if (prs_id == fccp_pkg::ID_STRM) begin
                  if (prs_strm_count != 16'hFFFF) prs_strm_count = prs_strm_count + 16'd1;
                  flux_next = {1'b0, prs_flux_sum} + {1'b0, prs_len};
                  prs_flux_sum = flux_next[32] ? 32'hFFFF_FFFF : flux_next[31:0];
               end
               prs_info_pending  = '0;
               prs_payload_count = '0;
               if (prs_len != 0) begin
                  prs_remaining = prs_len;
                  prs_phase     = fccp_pkg::PHASE_PAYLOAD;
               end else begin
                  prs_phase = fccp_pkg::PHASE_CHUNK_HDR;
               end
            end
         end
      endcase
      if (last) begin
         summary = '0;
         if (prs_phase != fccp_pkg::PHASE_FILE_HDR && prs_sig_good) begin
            summary.file_valid     = 1'b1;
            summary.format_version = prs_version;
            summary.disk_kind      = prs_info_committed[7:0];
            summary.write_protect  = prs_info_committed[15:8] != 8'h00;
            summary.sync_flag      = prs_info_committed[23:16] != 8'h00;
            summary.stream_chunks  = prs_strm_count;
            summary.flux_bytes     = prs_flux_sum;
         end
         expected_summaries.push_back(summary);
         clear_parser();
      end
   endtask

   // Offer one byte, with a random gap first, and wait for its transfer.
   task automatic send_byte(input logic [7:0] b, input logic last);
      @(negedge clock);
      if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      parse_byte(b, last);
      bytes_sent++;
   endtask

   // Send the whole file image, marking its final byte.
   task automatic send_file();
      for (int i = 0; i < file_image.size(); i++) begin
         send_byte(file_image[i], i == file_image.size() - 1);
      end
      files_sent++;
   endtask

   // Drop valid once no byte follows right away.
   task automatic release_req();
      @(negedge clock);
      req_valid     <= 1'b0;
      req_last_byte <= 1'b0;
   endtask

   task automatic push_word_le(input logic [31:0] w);
      for (int i = 0; i < 4; i++) begin
         file_image.push_back(w[8 * i +: 8]);
      end
   endtask

   task automatic push_signature(input logic [7:0] version_char);
      file_image.push_back(fccp_pkg::SIG_CHAR_0);
      file_image.push_back(fccp_pkg::SIG_CHAR_1);
      file_image.push_back(fccp_pkg::SIG_CHAR_2);
      file_image.push_back(version_char);
   endtask

   // Payload bytes lean toward zero so the flag fields see both values.
   function automatic logic [7:0] payload_value();
      return ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
   endfunction

   // Build a random file: mostly well formed, sometimes broken or cut short.
   task automatic build_random_file();
      int          n_chunks;
      int          cut;
      logic        huge;
      logic [31:0] id;
      logic [31:0] len;
      file_image.delete();
      if ($urandom_range(0, 19) == 0) begin
         repeat ($urandom_range(1, 20)) file_image.push_back(8'($urandom_range(0, 255)));
         return;
      end
      push_signature($urandom_range(0, 1) ? fccp_pkg::SIG_VER_3 : fccp_pkg::SIG_VER_2);
      if ($urandom_range(0, 9) == 0) file_image[$urandom_range(0, 3)] = 8'($urandom_range(0, 255));
      repeat (4) file_image.push_back(8'($urandom_range(0, 255)));
      n_chunks = $urandom_range(0, 3);
      for (int c = 0; c < n_chunks; c++) begin
         case ($urandom_range(0, 9))
            0, 1, 2: id = fccp_pkg::ID_INFO;
            3, 4, 5: id = fccp_pkg::ID_STRM;
            6, 7:    id = ($urandom_range(0, 1) ? fccp_pkg::ID_INFO : fccp_pkg::ID_STRM) ^
                          (32'd1 << $urandom_range(0, 31));
            default: id = $urandom;
         endcase
         huge = ($urandom_range(0, 9) == 0);
         len  = huge ? $urandom : 32'($urandom_range(0, 7));
         push_word_le(id);
         push_word_le(len);
         if (huge) begin
            // The file ends inside this payload.
            repeat ($urandom_range(0, 4)) file_image.push_back(payload_value());
            break;
         end
         for (int k = 0; k < int'(len); k++) file_image.push_back(payload_value());
      end
      // A partial trailing chunk header.
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 7)) file_image.push_back(8'($urandom_range(0, 255)));
      end
      // Cut the file short anywhere, the signature included.
      if ($urandom_range(0, 9) == 0) begin
         cut = $urandom_range(1, file_image.size());
         while (file_image.size() > cut) void'(file_image.pop_back());
      end
   endtask

   // Compare one summary field and report a mismatch.
   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // Result receiver: random stalls, or a long counted hold-off on request.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // Check each summary transfer against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_summaries.size() == 0) begin
            $display("%0t: summary transfer with no file pending", $time);
            fail_count++;
         end else begin
            head_summary = expected_summaries.pop_front();
            check_field("file_valid", head_summary.file_valid, rsp_file_valid);
            check_field("format_version", head_summary.format_version, rsp_format_version);
            check_field("disk_kind", head_summary.disk_kind, rsp_disk_kind);
            check_field("write_protect", head_summary.write_protect, rsp_write_protect);
            check_field("sync_flag", head_summary.sync_flag, rsp_sync_flag);
            check_field("stream_chunks", head_summary.stream_chunks, rsp_stream_chunks);
            check_field("flux_bytes", head_summary.flux_bytes, rsp_flux_bytes);
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("flux_container_chunk_parser: mismatch");
         $finish;
      end
   end

   // A one-byte file, a file with a full info chunk, and a stream header
   // whose payload runs past the end of the file.
   task automatic test_directed();
      send_gap_pct   = 0;
      recv_stall_pct = 0;
      file_image.delete();
      file_image.push_back(fccp_pkg::SIG_CHAR_0);
      send_file();

      file_image.delete();
      push_signature(fccp_pkg::SIG_VER_3);
      file_image = {file_image, 8'h00, 8'hFF, 8'h00, 8'hFF};
      push_word_le(fccp_pkg::ID_INFO);
      push_word_le(fccp_pkg::INFO_MIN_LEN);
      file_image = {file_image, 8'hFF, 8'hA5, 8'h01, 8'h00};
      send_file();

      file_image.delete();
      push_signature(fccp_pkg::SIG_VER_2);
      repeat (4) file_image.push_back(8'h00);
      push_word_le(fccp_pkg::ID_STRM);
      push_word_le(32'hFFFF_FFFF);
      send_file();
      release_req();
   endtask

   // Random files under one idle mix.
   task automatic test_random_traffic(input int gap_pct, input int stall_pct,
                                      input int byte_goal, input int file_goal);
      int byte_mark;
      int file_mark;
      send_gap_pct   = gap_pct;
      recv_stall_pct = stall_pct;
      byte_mark      = bytes_sent;
      file_mark      = files_sent;
      while (bytes_sent - byte_mark < byte_goal || files_sent - file_mark < file_goal) begin
         build_random_file();
         send_file();
      end
      release_req();
   endtask

   // Hold the result side off while short files keep coming, so the parser
   // fills up and stalls its input on a last byte.
   task automatic test_result_backpressure();
      send_gap_pct   = 0;
      recv_stall_pct = 0;
      @(posedge clock);
      hold_request = 400;
      repeat (6) begin
         file_image.delete();
         push_signature(fccp_pkg::SIG_VER_2);
         repeat (4) file_image.push_back(8'($urandom_range(0, 255)));
         send_file();
      end
      release_req();
   endtask

   // A short stream chunk followed by a stream header with a huge length
   // pushes the flux total past its limit, so it must saturate.
   task automatic test_flux_total_saturation();
      send_gap_pct   = 0;
      recv_stall_pct = 0;
      file_image.delete();
      push_signature(fccp_pkg::SIG_VER_3);
      repeat (4) file_image.push_back(8'h00);
      push_word_le(fccp_pkg::ID_STRM);
      push_word_le(32'd3);
      file_image = {file_image, 8'h11, 8'h22, 8'h33};
      push_word_le(fccp_pkg::ID_STRM);
      push_word_le(32'hFFFF_FFFE);
      send_file();
      release_req();
   endtask

   initial begin
      clear_parser();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_traffic(15, 66, 250, 10);
      test_random_traffic(66, 15, 250, 10);
      test_random_traffic(0, 0, 250, 10);
      test_result_backpressure();
      test_flux_total_saturation();

      // Drain outstanding summaries, then allow a few more cycles.
      while (expected_summaries.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("flux_container_chunk_parser: match");
      end else begin
         $display("flux_container_chunk_parser: mismatch");
      end
      $finish;
   end

endmodule

// ===== flux_container_chunk_parser.f =====
hdl/fccp_pkg.sv
hdl/flux_container_chunk_parser.sv
dv/flux_container_chunk_parser_tb.sv
